>>> hdl/tcw_pkg.sv
// tcw_pkg: constants, codes and types of the text console writer
// no dependencies; used by the channel interfaces and the top level

package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int CNT_W   = $clog2(CELLS + 1);
	localparam int SCNT_W  = $clog2(ROWS + 1);

	localparam int ACT_W      = 3;
	localparam int CHAR_W     = 8;
	localparam int ARG_W      = 8;
	localparam int COL_W      = 7;
	localparam int ROW_W      = 5;
	localparam int OFF_W      = 11;
	localparam int COLOR_W    = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [ACT_W-1:0] ACT_WRITE_CHAR   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR_SCREEN = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR_ROW    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SCROLL       = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SET_CURSOR   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_READ_CELL    = 3'd5;

	localparam logic [CHAR_W-1:0] NUL_CODE     = 8'd0;
	localparam logic [CHAR_W-1:0] TAB_CODE     = 8'd9;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

	localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 1'b1;

	localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 4'd15;
	localparam logic [COLOR_W-1:0] BACK_COLOR_RESET = 4'd0;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [CHAR_W-1:0] attr;
	} cell_t;

endpackage

>>> hdl/tcw_cmd_if.sv
// tcw_cmd_if: command channel of the text console writer
// depends on tcw_pkg

interface tcw_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::ACT_W-1:0]    action;
	logic [tcw_pkg::CHAR_W-1:0]   char_code;
	logic [tcw_pkg::ARG_W-1:0]    first_argument;
	logic [tcw_pkg::ARG_W-1:0]    second_argument;

	modport source (output valid, action, char_code, first_argument, second_argument,
		input ready);
	modport sink (input valid, action, char_code, first_argument, second_argument,
		output ready);
endinterface

>>> hdl/tcw_rsp_if.sv
// tcw_rsp_if: response channel of the text console writer
// depends on tcw_pkg

interface tcw_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::COL_W-1:0]    cursor_column;
	logic [tcw_pkg::ROW_W-1:0]    cursor_row;
	logic [tcw_pkg::OFF_W-1:0]    cursor_offset;
	logic [tcw_pkg::CHAR_W-1:0]   cell_char;
	logic [tcw_pkg::CHAR_W-1:0]   cell_attr;

	modport source (output valid, cursor_column, cursor_row, cursor_offset, cell_char,
		cell_attr, input ready);
	modport sink (input valid, cursor_column, cursor_row, cursor_offset, cell_char,
		cell_attr, output ready);
endinterface

>>> hdl/text_console_writer.sv
// text_console_writer: text-mode console engine with a screen memory and a cursor
// depends on tcw_pkg, tcw_cmd_if and tcw_rsp_if
//
// usage:
// cmd carries one command word (action, char_code, first_argument, second_argument),
// rsp returns one word per command: cursor column, row and linear offset after the
// command, plus the character and attribute of a read cell (zero for other actions).
// cfg_we/cfg_index/cfg_data set the text and back colours; write them while idle.
// response path, from the accepted command to the raise of rsp.valid:
//   plain character, newline, set cursor, terminator, unused action: the accepting edge
//   tab: via ST_TAB2 (then the scroll, if one is due); read cell: via ST_READ (memory read)
//   clear row: a sweep of the row in ST_FILL; clear screen: a sweep of all cells in ST_FILL
//   scroll, or a write past the bottom row: ST_SCRL0, then every cell in ST_SCROLL
// the screen memory has one write and one read port; clear and scroll sweep through it
// at one cell per cycle; an out-of-range row or cell, or a zero scroll, is answered from idle.
// one command is in flight at a time; cmd.ready is high only when the engine is idle and
// the response register is free or being taken, so a stalled receiver holds off the next
// command and short commands run at one per cycle.
// after reset the engine clears all COLUMNS*ROWS cells, one per cycle, before it
// takes its first command; colour writes are taken during that pass.

module text_console_writer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data,
	tcw_cmd_if.sink                          cmd,
	tcw_rsp_if.source                        rsp
);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_TAB2   = 3'd2;
	localparam logic [2:0] ST_SCRL0  = 3'd3;
	localparam logic [2:0] ST_SCROLL = 3'd4;
	localparam logic [2:0] ST_FILL   = 3'd5;
	localparam logic [2:0] ST_READ   = 3'd6;

	localparam int AW = tcw_pkg::ADDR_W;
	localparam int CW = tcw_pkg::COL_W;
	localparam int RW = tcw_pkg::ROW_W;

	logic [2:0]                          state_q;
	logic [AW-1:0]                       wr_q;
	logic [AW-1:0]                       end_q;
	logic [AW-1:0]                       shift_q;
	logic [tcw_pkg::CNT_W-1:0]           keep_q;
	logic                                tab_skip_q;
	logic                                scroll_pend_q;
	logic [CW-1:0]                       col_q;
	logic [RW-1:0]                       row_q;
	logic [tcw_pkg::COLOR_W-1:0]         text_q;
	logic [tcw_pkg::COLOR_W-1:0]         back_q;
	logic                                rsp_valid_q;
	tcw_pkg::cell_t                      cell_q;

	tcw_pkg::cell_t                      mem_q [tcw_pkg::CELLS];
	tcw_pkg::cell_t                      mem_rdata_q;
	logic                                mem_we;
	logic [AW-1:0]                       mem_waddr;
	tcw_pkg::cell_t                      mem_wdata;
	logic                                mem_re;
	logic [AW-1:0]                       mem_raddr;

	logic                                accept;
	logic [AW-1:0]                       cur_off;
	logic [tcw_pkg::CHAR_W-1:0]          attr;
	tcw_pkg::cell_t                      blank;
	logic                                is_nul;
	logic                                is_tab;
	logic                                is_nl;
	logic [CW:0]                         ncol;
	logic [RW:0]                         nrow;
	logic                                need_scroll;
	logic [tcw_pkg::SCNT_W-1:0]          scnt;
	logic [AW-1:0]                       scnt_shift;
	logic                                read_ok;
	logic [AW-1:0]                       read_addr;
	logic                                row_ok;
	logic [AW-1:0]                       row_start;
	logic [AW:0]                         scroll_src;

	assign accept  = cmd.valid & cmd.ready;
	assign cur_off = AW'(32'(row_q) * tcw_pkg::COLUMNS + 32'(col_q));
	assign attr    = {back_q, text_q};
	assign blank   = '{ch: tcw_pkg::NUL_CODE, attr: attr};
	assign is_nul  = cmd.char_code == tcw_pkg::NUL_CODE;
	assign is_tab  = cmd.char_code == tcw_pkg::TAB_CODE;
	assign is_nl   = cmd.char_code == tcw_pkg::NEWLINE_CODE;

	// cursor after a character write
	always_comb begin
		need_scroll = 1'b0;
		if (is_nl) begin
			ncol = '0;
			nrow = {1'b0, row_q} + (RW+1)'(1);
		end else begin
			ncol = {1'b0, col_q} + (is_tab ? (CW+1)'(2) : (CW+1)'(1));
			nrow = {1'b0, row_q};
		end
		if (32'(ncol) >= tcw_pkg::COLUMNS) begin
			ncol = '0;
			nrow = nrow + (RW+1)'(1);
		end
		if (32'(nrow) >= tcw_pkg::ROWS) begin
			nrow = (RW+1)'(tcw_pkg::ROWS - 1);
			ncol = '0;
			need_scroll = 1'b1;
		end
	end

	assign scnt       = (32'(cmd.first_argument) >= tcw_pkg::ROWS) ?
		tcw_pkg::SCNT_W'(tcw_pkg::ROWS) : tcw_pkg::SCNT_W'(cmd.first_argument);
	assign scnt_shift = AW'(32'(scnt) * tcw_pkg::COLUMNS);
	assign read_ok    = (32'(cmd.first_argument) < tcw_pkg::COLUMNS) &&
		(32'(cmd.second_argument) < tcw_pkg::ROWS);
	assign read_addr  = AW'(32'(cmd.second_argument) * tcw_pkg::COLUMNS +
		32'(cmd.first_argument));
	assign row_ok     = 32'(cmd.first_argument) < tcw_pkg::ROWS;
	assign row_start  = AW'(32'(cmd.first_argument) * tcw_pkg::COLUMNS);
	assign scroll_src = {1'b0, wr_q} + {1'b0, shift_q} + (AW+1)'(1);

	// memory port control; reads always run ahead of writes, so no address clash
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_q;
		mem_wdata = blank;
		mem_re    = 1'b0;
		mem_raddr = read_addr;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				if (accept && cmd.action == tcw_pkg::ACT_WRITE_CHAR && !is_nul && !is_nl) begin
					mem_we    = 1'b1;
					mem_waddr = cur_off;
					mem_wdata = '{ch: (is_tab ? tcw_pkg::NUL_CODE : cmd.char_code), attr: attr};
				end
				if (accept && cmd.action == tcw_pkg::ACT_READ_CELL && read_ok) begin
					mem_re = 1'b1;
				end
			end
			ST_TAB2: begin
				mem_we = !tab_skip_q;
			end
			ST_SCRL0: begin
				mem_re    = 32'(shift_q) < tcw_pkg::CELLS;
				mem_raddr = shift_q;
			end
			ST_SCROLL: begin
				mem_we    = 1'b1;
				mem_wdata = (tcw_pkg::CNT_W'(wr_q) < keep_q) ? mem_rdata_q : blank;
				mem_re    = 32'(scroll_src) < tcw_pkg::CELLS;
				mem_raddr = scroll_src[AW-1:0];
			end
			ST_FILL: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			wr_q          <= '0;
			end_q         <= '0;
			shift_q       <= '0;
			keep_q        <= '0;
			tab_skip_q    <= 1'b0;
			scroll_pend_q <= 1'b0;
			col_q         <= '0;
			row_q         <= '0;
			text_q        <= tcw_pkg::TEXT_COLOR_RESET;
			back_q        <= tcw_pkg::BACK_COLOR_RESET;
			rsp_valid_q   <= 1'b0;
			cell_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tcw_pkg::REG_TEXT_COLOR: text_q <= cfg_data;
					tcw_pkg::REG_BACK_COLOR: back_q <= cfg_data;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					wr_q <= AW'(32'(wr_q) + 1);
					if (32'(wr_q) == tcw_pkg::CELLS - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cell_q <= '0;
						case (cmd.action)
							tcw_pkg::ACT_WRITE_CHAR: begin
								if (is_nul) begin
									rsp_valid_q <= 1'b1;
								end else begin
									col_q <= ncol[CW-1:0];
									row_q <= nrow[RW-1:0];
									shift_q <= AW'(tcw_pkg::COLUMNS);
									keep_q  <= tcw_pkg::CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
									if (is_tab) begin
										wr_q          <= AW'(32'(cur_off) + 1);
										tab_skip_q    <= 32'(col_q) == tcw_pkg::COLUMNS - 1;
										scroll_pend_q <= need_scroll;
										state_q       <= ST_TAB2;
									end else if (need_scroll) begin
										state_q <= ST_SCRL0;
									end else begin
										rsp_valid_q <= 1'b1;
									end
								end
							end
							tcw_pkg::ACT_CLEAR_SCREEN: begin
								wr_q    <= '0;
								end_q   <= AW'(tcw_pkg::CELLS - 1);
								state_q <= ST_FILL;
							end
							tcw_pkg::ACT_CLEAR_ROW: begin
								if (row_ok) begin
									wr_q    <= row_start;
									end_q   <= AW'(32'(row_start) + tcw_pkg::COLUMNS - 1);
									state_q <= ST_FILL;
								end else begin
									rsp_valid_q <= 1'b1;
								end
							end
							tcw_pkg::ACT_SCROLL: begin
								if (scnt == '0) begin
									rsp_valid_q <= 1'b1;
								end else begin
									shift_q <= scnt_shift;
									keep_q  <= tcw_pkg::CNT_W'(tcw_pkg::CELLS - 32'(scnt_shift));
									state_q <= ST_SCRL0;
								end
							end
							tcw_pkg::ACT_SET_CURSOR: begin
								col_q <= (32'(cmd.first_argument) < tcw_pkg::COLUMNS) ?
									CW'(cmd.first_argument) : CW'(tcw_pkg::COLUMNS - 1);
								row_q <= (32'(cmd.second_argument) < tcw_pkg::ROWS) ?
									RW'(cmd.second_argument) : RW'(tcw_pkg::ROWS - 1);
								rsp_valid_q <= 1'b1;
							end
							tcw_pkg::ACT_READ_CELL: begin
								if (read_ok) begin
									state_q <= ST_READ;
								end else begin
									rsp_valid_q <= 1'b1;
								end
							end
							default: begin
								rsp_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_TAB2: begin
					if (scroll_pend_q) begin
						state_q <= ST_SCRL0;
					end else begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_SCRL0: begin
					wr_q    <= '0;
					state_q <= ST_SCROLL;
				end
				ST_SCROLL: begin
					wr_q <= AW'(32'(wr_q) + 1);
					if (32'(wr_q) == tcw_pkg::CELLS - 1) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_FILL: begin
					wr_q <= AW'(32'(wr_q) + 1);
					if (wr_q == end_q) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_READ: begin
					cell_q      <= mem_rdata_q;
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready         = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.cursor_column = col_q;
	assign rsp.cursor_row    = row_q;
	assign rsp.cursor_offset = tcw_pkg::OFF_W'(cur_off);
	assign rsp.cell_char     = cell_q.ch;
	assign rsp.cell_attr     = cell_q.attr;

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < tcw_pkg::COLUMNS) && (32'(row_q) < tcw_pkg::ROWS))
		else $error("cursor outside the screen");

	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> 32'(mem_waddr) < tcw_pkg::CELLS)
		else $error("screen write address out of range");

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("read and write of the same cell in one cycle");

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_INIT) |-> !rsp_valid_q)
		else $error("response pending while a command is in progress");
`endif

endmodule
